// ===== hw/rtl/sqe_pkg.sv =====
// sqe_pkg: shared types and constants for the stack/queue engine.
// Holds store geometry, command and status codes, and the controller/datapath
// command and status structs. No dependencies.
package sqe_pkg;

    localparam int DEPTH  = 32;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // command codes
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_DUMP = 3'd1;
    localparam logic [2:0] OP_PEEK = 3'd2;
    localparam logic [2:0] OP_SWAP = 3'd3;
    localparam logic [2:0] OP_NOP  = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [DATA_W-1:0] push_value;
    } sqe_cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_value;
        logic [1:0]               status;
        logic                     last_item;
    } sqe_rsp_t;

    // store address source: offset from the top, or the push slot
    typedef enum logic [1:0] {
        ASEL_TOP,
        ASEL_SECOND,
        ASEL_ITER,
        ASEL_PUSH
    } sqe_asel_t;

    // store write data source
    typedef enum logic [1:0] {
        WSEL_VALUE,
        WSEL_RDATA,
        WSEL_HOLD
    } sqe_wsel_t;

    typedef struct packed {
        logic       cmd_ld;
        logic       mem_en;
        logic       mem_we;
        sqe_asel_t  asel;
        sqe_wsel_t  wsel;
        logic       push_commit;
        logic       hold_ld;
        logic       iter_inc;
        logic       rsp_ld;
        logic       rsp_from_mem;
        logic [1:0] rsp_status;
        logic       rsp_last;
    } sqe_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic short_cnt;
        logic iter_end;
    } sqe_stat_t;

endpackage

// ===== hw/rtl/sqe_dpath.sv =====
// sqe_dpath: element store, ring pointers, dump iterator and result register.
// Depends on sqe_pkg; driven by sqe_ctrl through sqe_ctl_t.
module sqe_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  sqe_pkg::sqe_cmd_t  cmd,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  sqe_pkg::sqe_ctl_t  ctl,
    output sqe_pkg::sqe_stat_t stat,
    output logic               result_valid,
    output sqe_pkg::sqe_rsp_t  result
);
    import sqe_pkg::*;

    localparam logic [CNT_W:0] DEPTH_EXT = (CNT_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [DATA_W-1:0]        mem [DEPTH];
    logic [DATA_W-1:0]        rdata_reg;
    logic [DATA_W-1:0]        hold_reg;
    logic [DATA_W-1:0]        value_reg;
    logic                     queue_mode_reg;
    logic [IDX_W-1:0]         top_reg, top_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         iter_reg, iter_next;
    logic                     valid_reg;
    sqe_rsp_t                 rsp_reg;

    logic [CNT_W-1:0]         offset;
    logic [CNT_W:0]           sum;
    logic [IDX_W-1:0]         slot;
    logic [IDX_W-1:0]         below;
    logic [IDX_W-1:0]         addr;
    logic [DATA_W-1:0]        wdata;

    // ring slot: top plus offset, wrapped once
    always_comb
    begin
        case (ctl.asel)
            ASEL_TOP:    offset = '0;
            ASEL_SECOND: offset = CNT_W'(1);
            ASEL_ITER:   offset = iter_reg;
            ASEL_PUSH:   offset = count_reg;
            default:     offset = '0;
        endcase
        sum   = {{(CNT_W + 1 - IDX_W){1'b0}}, top_reg} + {1'b0, offset};
        slot  = (sum >= DEPTH_EXT) ? IDX_W'(sum - DEPTH_EXT) : IDX_W'(sum);
        below = (top_reg == '0) ? LAST_IDX : top_reg - IDX_W'(1);
        addr  = (ctl.asel == ASEL_PUSH && !queue_mode_reg) ? below : slot;
    end

    always_comb
    begin
        case (ctl.wsel)
            WSEL_VALUE: wdata = value_reg;
            WSEL_RDATA: wdata = rdata_reg;
            WSEL_HOLD:  wdata = hold_reg;
            default:    wdata = value_reg;
        endcase
    end

    always_comb
    begin
        top_next   = top_reg;
        count_next = count_reg;
        iter_next  = iter_reg;
        if (ctl.push_commit)
        begin
            count_next = count_reg + CNT_W'(1);
            if (!queue_mode_reg)
                top_next = below;
        end
        if (ctl.cmd_ld)
            iter_next = '0;
        else if (ctl.iter_inc)
            iter_next = iter_reg + CNT_W'(1);
    end

    // single-port store, read data registered
    always_ff @(posedge clk)
    begin
        if (ctl.mem_en)
        begin
            if (ctl.mem_we)
                mem[addr] <= wdata;
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cmd_ld)
            value_reg <= cmd.push_value;
        if (ctl.hold_ld)
            hold_reg <= rdata_reg;
        if (ctl.rsp_ld)
        begin
            rsp_reg.data_value <= ctl.rsp_from_mem ? rdata_reg : '0;
            rsp_reg.status     <= ctl.rsp_status;
            rsp_reg.last_item  <= ctl.rsp_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg        <= '0;
            count_reg      <= '0;
            iter_reg       <= '0;
            queue_mode_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            top_reg   <= top_next;
            count_reg <= count_next;
            iter_reg  <= iter_next;
            valid_reg <= ctl.rsp_ld;
            if (cfg_we)
                queue_mode_reg <= cfg_wdata;
        end
    end

    assign stat.full      = (count_reg == DEPTH_CNT);
    assign stat.empty     = (count_reg == '0);
    assign stat.short_cnt = (count_reg < CNT_W'(2));
    assign stat.iter_end  = (iter_reg == count_reg);

    assign result_valid = valid_reg;
    assign result       = rsp_reg;

endmodule

// ===== hw/rtl/sqe_ctrl.sv =====
// sqe_ctrl: command sequencer for the stack/queue engine.
// Depends on sqe_pkg; issues sqe_ctl_t to sqe_dpath and reads sqe_stat_t back.
module sqe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         opcode,
    input  sqe_pkg::sqe_stat_t stat,
    output sqe_pkg::sqe_ctl_t  ctl,
    output logic               busy
);
    import sqe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_DUMP,
        S_PEEK,
        S_SWAP_RD_B,
        S_SWAP_WR_A,
        S_SWAP_WR_B
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ctl        = '0;
        ctl.asel   = ASEL_TOP;
        ctl.wsel   = WSEL_VALUE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.cmd_ld = 1'b1;
                    op_next    = opcode;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_IDLE;
                case (op_reg)
                    OP_PUSH:
                    begin
                        if (stat.full)
                        begin
                            ctl.rsp_ld     = 1'b1;
                            ctl.rsp_status = ST_FULL;
                            ctl.rsp_last   = 1'b1;
                        end
                        else
                        begin
                            ctl.mem_en      = 1'b1;
                            ctl.mem_we      = 1'b1;
                            ctl.asel        = ASEL_PUSH;
                            ctl.push_commit = 1'b1;
                        end
                    end
                    OP_DUMP:
                    begin
                        if (!stat.empty)
                        begin
                            ctl.mem_en   = 1'b1;
                            ctl.asel     = ASEL_ITER;
                            ctl.iter_inc = 1'b1;
                            state_next   = S_DUMP;
                        end
                    end
                    OP_PEEK:
                    begin
                        if (stat.empty)
                        begin
                            ctl.rsp_ld     = 1'b1;
                            ctl.rsp_status = ST_EMPTY;
                            ctl.rsp_last   = 1'b1;
                        end
                        else
                        begin
                            ctl.mem_en = 1'b1;
                            state_next = S_PEEK;
                        end
                    end
                    OP_SWAP:
                    begin
                        if (stat.short_cnt)
                        begin
                            ctl.rsp_ld     = 1'b1;
                            ctl.rsp_status = ST_SHORT;
                            ctl.rsp_last   = 1'b1;
                        end
                        else
                        begin
                            ctl.mem_en = 1'b1;
                            state_next = S_SWAP_RD_B;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DUMP:
            begin
                // emit the element fetched last cycle, fetch the next one
                ctl.rsp_ld       = 1'b1;
                ctl.rsp_from_mem = 1'b1;
                ctl.rsp_status   = ST_OK;
                ctl.rsp_last     = stat.iter_end;
                if (stat.iter_end)
                    state_next = S_IDLE;
                else
                begin
                    ctl.mem_en   = 1'b1;
                    ctl.asel     = ASEL_ITER;
                    ctl.iter_inc = 1'b1;
                end
            end
            S_PEEK:
            begin
                ctl.rsp_ld       = 1'b1;
                ctl.rsp_from_mem = 1'b1;
                ctl.rsp_status   = ST_OK;
                ctl.rsp_last     = 1'b1;
                state_next       = S_IDLE;
            end
            S_SWAP_RD_B:
            begin
                ctl.hold_ld = 1'b1;
                ctl.mem_en  = 1'b1;
                ctl.asel    = ASEL_SECOND;
                state_next  = S_SWAP_WR_A;
            end
            S_SWAP_WR_A:
            begin
                ctl.mem_en = 1'b1;
                ctl.mem_we = 1'b1;
                ctl.asel   = ASEL_TOP;
                ctl.wsel   = WSEL_RDATA;
                state_next = S_SWAP_WR_B;
            end
            S_SWAP_WR_B:
            begin
                ctl.mem_en = 1'b1;
                ctl.mem_we = 1'b1;
                ctl.asel   = ASEL_SECOND;
                ctl.wsel   = WSEL_HOLD;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_NOP;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== hw/rtl/stack_queue_engine_top.sv =====
// stack_queue_engine_top: bounded stack/queue of signed 32-bit values.
// Depends on sqe_pkg, sqe_ctrl and sqe_dpath.
//
//   Channel   Signals                    Handshake
//   --------  -------------------------  ------------------------------------
//   request   start, busy, cmd           taken on an edge with start & !busy
//   result    result_valid, result       one-cycle strobe, no back-pressure
//   config    cfg_we, cfg_wdata          queue_mode written when cfg_we high
//
// Occupancy: after acceptance a request holds the block (busy high) through S_DISPATCH
//   alone for push, nop, an error or a dump of an empty store; S_DISPATCH then S_PEEK
//   for peek; S_DISPATCH, S_SWAP_RD_B, S_SWAP_WR_A and S_SWAP_WR_B for swap; S_DISPATCH
//   then one S_DUMP state per element for a dump. The single-port element store sets
//   these sequences: a swap needs two reads and two writes, and a dump reads one element a cycle.
// A result appears in the cycle after the state that produces it; dump results
//   come on consecutive cycles, the last marked by last_item.
// Reset: rst_n clears pointers, count, queue_mode and the sequencer; the
//   store itself is not cleared and no clearing pass is needed.
// The receiver cannot stall; results are never held back.
module stack_queue_engine_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sqe_pkg::sqe_cmd_t cmd,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    output logic              result_valid,
    output sqe_pkg::sqe_rsp_t result
);
    import sqe_pkg::*;

    sqe_ctl_t  ctl;
    sqe_stat_t stat;

    // sequencer: decodes the request and steps through store accesses
    sqe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (cmd.opcode),
        .stat   (stat),
        .ctl    (ctl),
        .busy   (busy)
    );

    // datapath: store, ring pointers, dump iterator, result register
    sqe_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .ctl          (ctl),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

    // an error result carries zero data and closes its request
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != ST_OK)
            |-> (result.data_value == '0 && result.last_item))
        else $error("error result with data or without last_item");

    // an accepted request always makes the block busy from the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // a dump burst is unbroken until its last element
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_item) |=> result_valid)
        else $error("dump burst broken before last element");

    // after the closing result there is a gap before any further result
    a_burst_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_item) |=> !result_valid)
        else $error("result right after a closing result");

    // the controller never issues a result together with a store write
    a_no_rsp_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.mem_we |-> !ctl.rsp_ld)
        else $error("result load during store write");

endmodule

// ===== dv/sqe_result_checker.sv =====
// sqe_result_checker: predicts and checks every result of the stack/queue engine.
// Watches the request, result and config channels of stack_queue_engine_top.
// Depends on sqe_pkg only.
`timescale 1ns / 1ps

module sqe_result_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  sqe_pkg::sqe_cmd_t cmd,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              result_valid,
    input  sqe_pkg::sqe_rsp_t result,
    output int                fail_count,
    output int                pending
);
    import sqe_pkg::*;

    logic signed [DATA_W-1:0] elem_mem [DEPTH];
    logic [IDX_W-1:0]         top_idx;
    logic [CNT_W-1:0]         elem_cnt;
    logic                     queue_mode;
    sqe_rsp_t                 rsp_due [$];

    function automatic int slot_of(int k);
        return (int'(top_idx) + k) % DEPTH;
    endfunction

    task automatic push_rsp(logic signed [DATA_W-1:0] data, logic [1:0] st, logic last);
        sqe_rsp_t r;
        r.data_value = data;
        r.status     = st;
        r.last_item  = last;
        rsp_due.push_back(r);
    endtask

    // Advance the predicted store by one request and queue the results it causes.
    task automatic apply_command(sqe_cmd_t c);
        int k;
        int a;
        int b;
        logic signed [DATA_W-1:0] t;
        case (c.opcode)
            OP_PUSH:
            begin
                if (elem_cnt >= DEPTH)
                    push_rsp('0, ST_FULL, 1'b1);
                else
                begin
                    if (queue_mode)
                        elem_mem[slot_of(int'(elem_cnt))] = c.push_value;
                    else
                    begin
                        top_idx = IDX_W'((int'(top_idx) + DEPTH - 1) % DEPTH);
                        elem_mem[top_idx] = c.push_value;
                    end
                    elem_cnt = elem_cnt + 1'b1;
                end
            end
            OP_DUMP:
            begin
                for (k = 0; k < int'(elem_cnt); k++)
                    push_rsp(elem_mem[slot_of(k)], ST_OK, (k + 1 == int'(elem_cnt)));
            end
            OP_PEEK:
            begin
                if (elem_cnt == 0)
                    push_rsp('0, ST_EMPTY, 1'b1);
                else
                    push_rsp(elem_mem[slot_of(0)], ST_OK, 1'b1);
            end
            OP_SWAP:
            begin
                if (elem_cnt < 2)
                    push_rsp('0, ST_SHORT, 1'b1);
                else
                begin
                    a = slot_of(0);
                    b = slot_of(1);
                    t = elem_mem[a];
                    elem_mem[a] = elem_mem[b];
                    elem_mem[b] = t;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result(sqe_rsp_t got);
        sqe_rsp_t want;
        if (rsp_due.size() == 0)
        begin
            $error("unexpected result: data_value=%0d status=%0d last_item=%0d",
                   got.data_value, got.status, got.last_item);
            fail_count++;
        end
        else
        begin
            want = rsp_due.pop_front();
            if (got.data_value !== want.data_value)
            begin
                $error("data_value mismatch: expected %0d, actual %0d",
                       want.data_value, got.data_value);
                fail_count++;
            end
            if (got.status !== want.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                fail_count++;
            end
            if (got.last_item !== want.last_item)
            begin
                $error("last_item mismatch: expected %0d, actual %0d",
                       want.last_item, got.last_item);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_due.delete();
            top_idx    = '0;
            elem_cnt   = '0;
            queue_mode = 1'b0;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // results belong to earlier requests, so check them first
            if (result_valid)
                check_result(result);
            if (cfg_we)
                queue_mode = cfg_wdata;
            if (start && !busy)
                apply_command(cmd);
            pending = rsp_due.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// tb: top of the stack/queue engine testbench; drives requests and config, gives the verdict.
// Instantiates stack_queue_engine_top and sqe_result_checker; uses sqe_pkg types.
`timescale 1ns / 1ps

module tb;
    import sqe_pkg::*;

    // reserved opcodes, which the block treats as nop
    localparam logic [2:0] OP_RSVD_LO = 3'd5;
    localparam logic [2:0] OP_RSVD_MID = 3'd6;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;

    localparam int PHASE_ITEMS = 72;
    // longest legal quiet stretch is a config pause, a sender gap or the final drain; allow far more
    localparam int QUIET_LIMIT = 1000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    sqe_cmd_t cmd;
    logic     cfg_we;
    logic     cfg_wdata;
    logic     result_valid;
    sqe_rsp_t result;
    int       fail_count;
    int       pending;

    int       quiet_cycles;
    int       stored_count;  // elements the block holds, as far as stimulus shaping needs
    bit       gap_on;

    stack_queue_engine_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

    sqe_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: count edges at which neither a request nor a result moves.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((start && !busy) || result_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("stack_queue_engine_top verification failed");
                $finish;
            end
        end
    end

    // Pick a push value: extremes often, otherwise any 32-bit pattern.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return {1'b1, {(DATA_W-1){1'b0}}};
        else if (r < 20)
            return {1'b0, {(DATA_W-1){1'b1}}};
        else if (r < 25)
            return '0;
        else if (r < 30)
            return '1;
        return $urandom;
    endfunction

    // Mix of commands; pushes dominate so the store fills over the run.
    function automatic logic [2:0] pick_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return OP_PUSH;
        else if (r < 40)
            return OP_DUMP;
        else if (r < 60)
            return OP_PEEK;
        else if (r < 85)
            return OP_SWAP;
        else if (r < 93)
            return OP_NOP;
        else if (r < 96)
            return OP_RSVD_LO;
        else if (r < 98)
            return OP_RSVD_MID;
        return OP_RSVD_HI;
    endfunction

    // Send one request. Called at a falling edge; returns at the falling edge
    // after acceptance with start still high, so back-to-back requests need no
    // drop of start.
    task automatic issue(logic [2:0] op, logic signed [DATA_W-1:0] val);
        bit taken;
        if (gap_on && $urandom_range(0, 99) < 13)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        start          = 1'b1;
        cmd.opcode     = op;
        cmd.push_value = val;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
        end
        @(negedge clk);
        if (op == OP_PUSH && stored_count < DEPTH)
            stored_count++;
    endtask

    task automatic issue_random();
        issue(pick_opcode(), pick_value());
    endtask

    // Write queue_mode only while idle: drain results and let a trailing push or
    // swap finish, then pause before the write.
    task automatic write_mode(logic m);
        start = 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = m;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        cmd.opcode     = OP_NOP;
        cmd.push_value = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        stored_count   = 0;
        gap_on         = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty-store errors, reserved opcodes, value extremes, stack mode.
        issue(OP_PEEK, pick_value());        // peek on empty store
        issue(OP_SWAP, pick_value());        // swap with nothing stored
        issue(OP_DUMP, pick_value());        // dump of empty store: silent
        issue(OP_NOP, pick_value());
        issue(OP_RSVD_LO, pick_value());
        issue(OP_RSVD_MID, pick_value());
        issue(OP_RSVD_HI, pick_value());
        issue(OP_PUSH, {1'b1, {(DATA_W-1){1'b0}}});
        issue(OP_SWAP, pick_value());        // swap with one element
        issue(OP_PEEK, pick_value());
        issue(OP_DUMP, pick_value());        // single-element dump
        issue(OP_PUSH, {1'b0, {(DATA_W-1){1'b1}}});
        issue(OP_PUSH, '0);
        issue(OP_PUSH, '1);
        issue(OP_PEEK, pick_value());
        issue(OP_SWAP, pick_value());
        issue(OP_PEEK, pick_value());
        issue(OP_DUMP, pick_value());
        issue(OP_PUSH, $urandom);
        issue(OP_NOP, pick_value());
        issue(OP_DUMP, pick_value());

        // Queue mode on a partly filled store.
        write_mode(1'b1);
        repeat (PHASE_ITEMS) issue_random();

        // Stack mode with no sender gaps at all.
        write_mode(1'b0);
        gap_on = 1'b0;
        repeat (PHASE_ITEMS) issue_random();
        gap_on = 1'b1;

        // Queue mode: top off the store, then hit the full case and keep going.
        write_mode(1'b1);
        while (stored_count < DEPTH)
            issue(OP_PUSH, pick_value());
        issue(OP_PUSH, pick_value());
        issue(OP_DUMP, pick_value());
        repeat (PHASE_ITEMS) issue_random();

        // Stack mode on a full store.
        write_mode(1'b0);
        repeat (PHASE_ITEMS) issue_random();

        // Drain: wait out every expected result, then keep watching for strays.
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (fail_count == 0)
            $display("stack_queue_engine_top verification clean");
        else
            $display("stack_queue_engine_top verification failed");
        $finish;
    end

endmodule

// ===== stack_queue_engine_top.f =====
hw/rtl/sqe_pkg.sv
hw/rtl/sqe_dpath.sv
hw/rtl/sqe_ctrl.sv
hw/rtl/stack_queue_engine_top.sv
dv/sqe_result_checker.sv
dv/tb.sv
